[design/assert_macros.svh]
// Assertion macros used by the core of the box refit block.
// The macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cbncr_pkg.sv]
// Shared types and constants of the nearest-corner box refit block.
// No dependencies; used by cbncr_cfg_regs and the top level.
package cbncr_pkg;

    localparam int DIM_W      = 16;
    localparam int POS_W      = 24;
    localparam int QUAT_W     = 16;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 104;

    // One in Q.28, the scale of the rotation matrix entries.
    localparam logic signed [34:0] ROT_ONE = 35'sd268435456;
    // Rounding offsets for the shifts by 27 and by 29 bits.
    localparam logic signed [53:0] RND_27 = 54'sd67108864;
    localparam logic signed [53:0] RND_29 = 54'sd268435456;

    localparam logic signed [25:0] POS_MAX = 26'sd8388607;
    localparam logic signed [25:0] POS_MIN = -26'sd8388608;

    typedef enum logic [1:0]
    {
        CFG_WIDTH_LOWER  = 2'd0,
        CFG_WIDTH_UPPER  = 2'd1,
        CFG_LENGTH_LOWER = 2'd2,
        CFG_LENGTH_UPPER = 2'd3
    } cfg_idx_t;

    typedef struct packed
    {
        logic [DIM_W-1:0] width_lower;
        logic [DIM_W-1:0] width_upper;
        logic [DIM_W-1:0] length_lower;
        logic [DIM_W-1:0] length_upper;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        width_lower:  16'd1229,
        width_upper:  16'd2253,
        length_lower: 16'd3072,
        length_upper: 16'd5120
    };

    // Keep a dimension that lies strictly inside (lo, hi), else take the midpoint.
    // A zero dimension stays zero.
    function automatic logic [DIM_W-1:0] pick_dim(input logic [DIM_W-1:0] dim,
                                                  input logic [DIM_W-1:0] lo,
                                                  input logic [DIM_W-1:0] hi);
        logic [DIM_W:0] mid_sum;
        mid_sum = {1'b0, lo} + {1'b0, hi};
        priority if (dim == '0)
        begin
            pick_dim = '0;
        end
        else if ((lo < dim) && (dim < hi))
        begin
            pick_dim = dim;
        end
        else
        begin
            pick_dim = mid_sum[DIM_W:1];
        end
    endfunction

endpackage

[design/cbncr_cfg_regs.sv]
// APB register file holding the four dimension bounds of the box refit block.
// Depends on cbncr_pkg for the register layout and reset values.
module cbncr_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbncr_pkg::PADDR_W-1:0]        paddr,
    input  logic [cbncr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbncr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output cbncr_pkg::cfg_t                      cfg
);
    import cbncr_pkg::*;

    cfg_t     cfg_reg;
    cfg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cfg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                CFG_WIDTH_LOWER:  cfg_reg.width_lower  <= pwdata[DIM_W-1:0];
                CFG_WIDTH_UPPER:  cfg_reg.width_upper  <= pwdata[DIM_W-1:0];
                CFG_LENGTH_LOWER: cfg_reg.length_lower <= pwdata[DIM_W-1:0];
                CFG_LENGTH_UPPER: cfg_reg.length_upper <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            CFG_WIDTH_LOWER:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.width_lower};
            CFG_WIDTH_UPPER:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.width_upper};
            CFG_LENGTH_LOWER: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.length_lower};
            CFG_LENGTH_UPPER: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.length_upper};
        endcase
    end

endmodule

[design/car_box_nearest_corner_refit_core.sv]
// Nearest-corner box refit core: eight register stages, depends on cbncr_pkg,
// cbncr_cfg_regs and assert_macros.svh.
// A box accepted into stage 0 moves through stages 1 to 7 and shows its result on m_tdata.
// Throughput: one box per cycle; each stage holds while the stage after it is full
// and stalled, so the input only stalls once all eight stages hold items.
// Reset (rst_n, asynchronous) empties the pipeline and loads the default bounds.
`include "assert_macros.svh"

module car_box_nearest_corner_refit_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input box. s_tdata from bit 0 up: box_length[15:0], box_width[31:16],
    // centre_x[55:32], centre_y[79:56], centre_z[103:80], quat_x[119:104],
    // quat_y[135:120], quat_z[151:136], quat_w[167:152].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cbncr_pkg::IN_DATA_W-1:0]      s_tdata,
    // Refit box. m_tdata from bit 0 up: new_length[15:0], new_width[31:16],
    // new_centre_x[55:32], new_centre_y[79:56], new_centre_z[103:80].
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cbncr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration port for the dimension bounds.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbncr_pkg::PADDR_W-1:0]        paddr,
    input  logic [cbncr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbncr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import cbncr_pkg::*;

    // Stage map:
    //   0  quaternion products, new dimensions, dimension changes
    //   1  rotation matrix entries in Q.28 (first two columns only)
    //   2  products of the matrix with the half extents and with the changes
    //   3  world coordinates of the four corners in Q.12
    //   4  squares of the corner coordinates
    //   5  squared distance of each corner
    //   6  nearest corner, first one wins ties
    //   7  shifted and saturated centre, output register
    localparam int NUM_STAGES = 8;

    // Dimensions and centre travel alongside the arithmetic.
    typedef struct packed
    {
        logic [DIM_W-1:0]            nl;
        logic [DIM_W-1:0]            nw;
        logic [2:0][POS_W-1:0]       cen;
    } side_t;

    // Centre shift products: rotation column times the dimension change.
    typedef struct packed
    {
        logic [2:0][51:0] e;
        logic [2:0][51:0] f;
    } shift_t;

    cfg_t cfg;

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] rdy;

    side_t  side_reg [7];
    side_t  side_next;
    shift_t ef_reg [2:6];
    shift_t ef_next;

    // Stage 0
    logic signed [31:0] qxx_reg, qyy_reg, qzz_reg, qxy_reg, qzw_reg;
    logic signed [31:0] qxz_reg, qyw_reg, qyz_reg, qxw_reg;
    logic signed [31:0] qxx_next, qyy_next, qzz_next, qxy_next, qzw_next;
    logic signed [31:0] qxz_next, qyw_next, qyz_next, qxw_next;
    logic [DIM_W-1:0]   len0_reg, wid0_reg;
    logic signed [16:0] dl0_reg, dw0_reg;
    logic signed [16:0] dl_next, dw_next;
    logic signed [15:0] qx, qy, qz, qw;
    logic [DIM_W-1:0]   len_in, wid_in;

    // Stage 1
    logic signed [34:0] r0_reg [3];
    logic signed [34:0] r1_reg [3];
    logic signed [34:0] r0_next [3];
    logic signed [34:0] r1_next [3];
    logic [DIM_W-1:0]   len1_reg, wid1_reg;
    logic signed [16:0] dl1_reg, dw1_reg;

    // Stage 2
    logic signed [51:0] a2_reg [3];
    logic signed [51:0] b2_reg [3];
    logic signed [51:0] a_next [3];
    logic signed [51:0] b_next [3];

    // Stages 3 to 6
    logic signed [27:0] c3_reg [4][3];
    logic signed [27:0] c_next [4][3];
    logic [54:0]        sq4_reg [4][3];
    logic [54:0]        sq_next [4][3];
    logic [56:0]        d5_reg [4];
    logic [56:0]        d_next [4];
    logic [3:0]         sel6_reg;
    logic [3:0]         sel_next;

    // Stage 7
    logic [DIM_W-1:0]      out_nl_reg, out_nw_reg;
    logic [2:0][POS_W-1:0] out_cen_reg;
    logic [2:0][POS_W-1:0] out_cen_next;

    function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
        sx35 = $signed({{3{v[31]}}, v});
    endfunction

    function automatic logic signed [53:0] sx54(input logic [51:0] v);
        sx54 = $signed({{2{v[51]}}, v});
    endfunction

    cbncr_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A stage takes new contents when it is empty or its contents move on.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = {out_cen_reg, out_nw_reg, out_nl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: unpack, quaternion products and dimension selection.
    always_comb
    begin
        len_in = s_tdata[15:0];
        wid_in = s_tdata[31:16];
        qx     = $signed(s_tdata[119:104]);
        qy     = $signed(s_tdata[135:120]);
        qz     = $signed(s_tdata[151:136]);
        qw     = $signed(s_tdata[167:152]);

        qxx_next = qx * qx;
        qyy_next = qy * qy;
        qzz_next = qz * qz;
        qxy_next = qx * qy;
        qzw_next = qz * qw;
        qxz_next = qx * qz;
        qyw_next = qy * qw;
        qyz_next = qy * qz;
        qxw_next = qx * qw;

        side_next.nl     = pick_dim(len_in, cfg.length_lower, cfg.length_upper);
        side_next.nw     = pick_dim(wid_in, cfg.width_lower, cfg.width_upper);
        side_next.cen[0] = s_tdata[55:32];
        side_next.cen[1] = s_tdata[79:56];
        side_next.cen[2] = s_tdata[103:80];

        dl_next = $signed({1'b0, len_in}) - $signed({1'b0, side_next.nl});
        dw_next = $signed({1'b0, wid_in}) - $signed({1'b0, side_next.nw});
    end

    // Stage 1: the two matrix columns that act on the footprint.
    always_comb
    begin
        r0_next[0] = ROT_ONE - ((sx35(qyy_reg) + sx35(qzz_reg)) <<< 1);
        r1_next[0] = (sx35(qxy_reg) - sx35(qzw_reg)) <<< 1;
        r0_next[1] = (sx35(qxy_reg) + sx35(qzw_reg)) <<< 1;
        r1_next[1] = ROT_ONE - ((sx35(qxx_reg) + sx35(qzz_reg)) <<< 1);
        r0_next[2] = (sx35(qxz_reg) - sx35(qyw_reg)) <<< 1;
        r1_next[2] = (sx35(qyz_reg) + sx35(qxw_reg)) <<< 1;
    end

    // Stage 2: one product per matrix entry for the corners and one for the shift.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_next[i]    = r0_reg[i] * $signed({1'b0, len1_reg});
            b_next[i]    = r1_reg[i] * $signed({1'b0, wid1_reg});
            ef_next.e[i] = r0_reg[i] * dl1_reg;
            ef_next.f[i] = r1_reg[i] * dw1_reg;
        end
    end

    // Stage 3: corner k has the length sign negative when bit 0 of k is set
    // and the width sign negative when bit 1 is set.
    always_comb
    begin
        logic signed [53:0] sa;
        logic signed [53:0] sb;
        logic signed [53:0] acc;
        logic signed [27:0] cen4;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sa   = sx54(a2_reg[i]);
                sb   = sx54(b2_reg[i]);
                if (k[0])
                begin
                    sa = -sa;
                end
                if (k[1])
                begin
                    sb = -sb;
                end
                acc  = sa + sb + RND_27;
                cen4 = $signed({{2{side_reg[2].cen[i][POS_W-1]}}, side_reg[2].cen[i], 2'b00});
                c_next[k][i] = $signed({acc[53], acc[53:27]}) + cen4;
            end
        end
    end

    // Stage 4: squares of the corner coordinates.
    always_comb
    begin
        logic signed [55:0] prod;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod = c3_reg[k][i] * c3_reg[k][i];
                sq_next[k][i] = prod[54:0];
            end
        end
    end

    // Stage 5: squared distance of each corner.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d_next[k] = {2'b00, sq4_reg[k][0]} + {2'b00, sq4_reg[k][1]}
                      + {2'b00, sq4_reg[k][2]};
        end
    end

    // Stage 6: a two-level compare tree. A later corner wins only when strictly
    // nearer, which matches a first-wins scan over the corners.
    always_comb
    begin
        logic        w01;
        logic        w23;
        logic        whi;
        logic [56:0] dm01;
        logic [56:0] dm23;
        logic [1:0]  idx;
        w01  = d5_reg[1] < d5_reg[0];
        w23  = d5_reg[3] < d5_reg[2];
        dm01 = w01 ? d5_reg[1] : d5_reg[0];
        dm23 = w23 ? d5_reg[3] : d5_reg[2];
        whi  = dm23 < dm01;
        idx  = whi ? {1'b1, w23} : {1'b0, w01};
        sel_next = 4'b0001 << idx;
    end

    // Stage 7: pull the centre back from the kept corner and saturate.
    always_comb
    begin
        logic               neg_x;
        logic               neg_y;
        logic signed [53:0] se;
        logic signed [53:0] sf;
        logic signed [53:0] acc;
        logic signed [25:0] sum;
        neg_x = sel6_reg[1] || sel6_reg[3];
        neg_y = sel6_reg[2] || sel6_reg[3];
        for (int i = 0; i < 3; i++)
        begin
            se = sx54(ef_reg[6].e[i]);
            sf = sx54(ef_reg[6].f[i]);
            if (neg_x)
            begin
                se = -se;
            end
            if (neg_y)
            begin
                sf = -sf;
            end
            acc = se + sf + RND_29;
            sum = $signed({acc[53], acc[53:29]})
                + $signed({{2{side_reg[6].cen[i][POS_W-1]}}, side_reg[6].cen[i]});
            priority if (sum > POS_MAX)
            begin
                out_cen_next[i] = POS_MAX[POS_W-1:0];
            end
            else if (sum < POS_MIN)
            begin
                out_cen_next[i] = POS_MIN[POS_W-1:0];
            end
            else
            begin
                out_cen_next[i] = sum[POS_W-1:0];
            end
        end
    end

    // Payload registers: loaded whenever their stage takes new contents.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            qxx_reg     <= qxx_next;
            qyy_reg     <= qyy_next;
            qzz_reg     <= qzz_next;
            qxy_reg     <= qxy_next;
            qzw_reg     <= qzw_next;
            qxz_reg     <= qxz_next;
            qyw_reg     <= qyw_next;
            qyz_reg     <= qyz_next;
            qxw_reg     <= qxw_next;
            len0_reg    <= len_in;
            wid0_reg    <= wid_in;
            dl0_reg     <= dl_next;
            dw0_reg     <= dw_next;
            side_reg[0] <= side_next;
        end
        if (rdy[1])
        begin
            r0_reg      <= r0_next;
            r1_reg      <= r1_next;
            len1_reg    <= len0_reg;
            wid1_reg    <= wid0_reg;
            dl1_reg     <= dl0_reg;
            dw1_reg     <= dw0_reg;
        end
        if (rdy[2])
        begin
            a2_reg      <= a_next;
            b2_reg      <= b_next;
            ef_reg[2]   <= ef_next;
        end
        if (rdy[3])
        begin
            c3_reg      <= c_next;
        end
        if (rdy[4])
        begin
            sq4_reg     <= sq_next;
        end
        if (rdy[5])
        begin
            d5_reg      <= d_next;
        end
        if (rdy[6])
        begin
            sel6_reg    <= sel_next;
        end
        for (int k = 1; k < 7; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        for (int k = 3; k < 7; k++)
        begin
            if (rdy[k])
            begin
                ef_reg[k] <= ef_reg[k-1];
            end
        end
        if (rdy[7])
        begin
            out_nl_reg  <= side_reg[6].nl;
            out_nw_reg  <= side_reg[6].nw;
            out_cen_reg <= out_cen_next;
        end
    end

    // The output stage is empty while reset is applied.
    `ASSERT_ALWAYS(a_out_empty_in_reset, !rst_n |-> !m_tvalid, "output valid during reset")

    // A full first stage that cannot move on keeps its item.
    `ASSERT_CLK(a_stage0_hold,
        v_reg[0] && !rdy[1] |=> v_reg[0] && $stable(len0_reg) && $stable(dl0_reg),
        "stage 0 item lost under stall")

    // Exactly one corner is chosen for every item in the selection stage.
    `ASSERT_CLK(a_sel_onehot, v_reg[6] |-> $onehot(sel6_reg), "nearest corner select not one-hot")

    // A zero length gives a zero new length and no shift along the box x axis.
    `ASSERT_CLK(a_zero_len,
        v_reg[0] && (len0_reg == '0) |-> (dl0_reg == '0) && (side_reg[0].nl == '0),
        "zero length not kept")

endmodule

[tb/cbncr_refit_checker.sv]
// Scoreboard for the nearest-corner box refit core: watches the box streams and the
// configuration port, predicts each refit box and compares it with what comes out.
// Depends on cbncr_pkg for the stream widths and the register indexes.
module cbncr_refit_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [cbncr_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [cbncr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbncr_pkg::PADDR_W-1:0]        paddr,
    input  logic [cbncr_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                 pready,
    output int                                   refits_pending,
    output int                                   mismatch_count
);

    localparam longint UNIT_Q28  = longint'(1) <<< 28;

    // Same layout as m_tdata, so a result word maps straight onto it.
    typedef struct packed
    {
        logic signed [23:0] new_centre_z;
        logic signed [23:0] new_centre_y;
        logic signed [23:0] new_centre_x;
        logic [15:0]        new_width;
        logic [15:0]        new_length;
    } refit_t;

    logic [15:0] width_lo;
    logic [15:0] width_hi;
    logic [15:0] length_lo;
    logic [15:0] length_hi;

    refit_t refit_q [$];
    refit_t want_box;
    refit_t seen_box;

    // Arithmetic right shift floors, so adding half an LSB first rounds half up.
    function automatic longint round_off(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic longint fit_dim(input longint dim, input longint lo, input longint hi);
        if (dim == 0)
            return 0;
        if ((lo < dim) && (dim < hi))
            return dim;
        return (lo + hi) >>> 1;
    endfunction

    function automatic refit_t predict_refit(input logic [cbncr_pkg::IN_DATA_W-1:0] box);
        longint len, wid, new_len, new_wid, qx, qy, qz, qw, px, py, dx, dy, pt;
        longint cen [3];
        longint rot [3][2];
        longint moved [3];
        longint unsigned sq_sum, best;
        int sx, sy, ax, ay;
        refit_t res;
        len    = longint'(box[15:0]);
        wid    = longint'(box[31:16]);
        cen[0] = longint'($signed(box[55:32]));
        cen[1] = longint'($signed(box[79:56]));
        cen[2] = longint'($signed(box[103:80]));
        qx     = longint'($signed(box[119:104]));
        qy     = longint'($signed(box[135:120]));
        qz     = longint'($signed(box[151:136]));
        qw     = longint'($signed(box[167:152]));

        // Rotation columns for the box x and y axes, Q.28, quaternion taken as given.
        rot[0][0] = UNIT_Q28 - 2 * (qy * qy + qz * qz);
        rot[0][1] = 2 * (qx * qy - qz * qw);
        rot[1][0] = 2 * (qx * qy + qz * qw);
        rot[1][1] = UNIT_Q28 - 2 * (qx * qx + qz * qz);
        rot[2][0] = 2 * (qx * qz - qy * qw);
        rot[2][1] = 2 * (qy * qz + qx * qw);

        // Corner order (+,+), (-,+), (+,-), (-,-); only a strictly nearer corner replaces.
        best = 0;
        sx = 1;
        sy = 1;
        for (int k = 0; k < 4; k++)
        begin
            ax = (k & 1) ? -1 : 1;
            ay = (k & 2) ? -1 : 1;
            px = ax * len;
            py = ay * wid;
            sq_sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                pt = round_off(rot[i][0] * px + rot[i][1] * py, 27) + cen[i] * 4;
                sq_sum = sq_sum + pt * pt;
            end
            if ((k == 0) || (sq_sum < best))
            begin
                best = sq_sum;
                sx = ax;
                sy = ay;
            end
        end

        new_len = fit_dim(len, longint'(length_lo), longint'(length_hi));
        new_wid = fit_dim(wid, longint'(width_lo), longint'(width_hi));
        dx = sx * (len - new_len);
        dy = sy * (wid - new_wid);
        for (int i = 0; i < 3; i++)
            moved[i] = cen[i] + round_off(rot[i][0] * dx + rot[i][1] * dy, 29);

        res.new_length   = new_len[15:0];
        res.new_width    = new_wid[15:0];
        res.new_centre_x = clamp24(moved[0]);
        res.new_centre_y = clamp24(moved[1]);
        res.new_centre_z = clamp24(moved[2]);
        return res;
    endfunction

    task automatic show_diff(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_lo  <= 16'd1229;
            width_hi  <= 16'd2253;
            length_lo <= 16'd3072;
            length_hi <= 16'd5120;
            refit_q.delete();
            refits_pending <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cbncr_pkg::cfg_idx_t'(paddr[3:2]))
                    cbncr_pkg::CFG_WIDTH_LOWER:  width_lo  <= pwdata[15:0];
                    cbncr_pkg::CFG_WIDTH_UPPER:  width_hi  <= pwdata[15:0];
                    cbncr_pkg::CFG_LENGTH_LOWER: length_lo <= pwdata[15:0];
                    cbncr_pkg::CFG_LENGTH_UPPER: length_hi <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                refit_q.insert(refit_q.size(), predict_refit(s_tdata));

            if (m_tvalid && m_tready)
            begin
                seen_box = refit_t'(m_tdata);
                if (refit_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result transfer with none expected, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want_box = refit_q.pop_front();
                    if (seen_box.new_length !== want_box.new_length)
                        show_diff("new_length", want_box.new_length, seen_box.new_length);
                    if (seen_box.new_width !== want_box.new_width)
                        show_diff("new_width", want_box.new_width, seen_box.new_width);
                    if (seen_box.new_centre_x !== want_box.new_centre_x)
                        show_diff("new_centre_x", want_box.new_centre_x,
                                  seen_box.new_centre_x);
                    if (seen_box.new_centre_y !== want_box.new_centre_y)
                        show_diff("new_centre_y", want_box.new_centre_y,
                                  seen_box.new_centre_y);
                    if (seen_box.new_centre_z !== want_box.new_centre_z)
                        show_diff("new_centre_z", want_box.new_centre_z,
                                  seen_box.new_centre_z);
                end
            end

            refits_pending <= refit_q.size();
        end
    end

endmodule

[tb/car_box_nearest_corner_refit_core_tb.sv]
// Top of the testbench for the nearest-corner box refit core: clock, reset, box
// stimulus, result back-pressure, register writes and the final verdict.
// Depends on cbncr_pkg, the core itself and cbncr_refit_checker.
module car_box_nearest_corner_refit_core_tb;

    // Idle cycles (no transfer on any port) after which the run is declared hung.
    localparam int  WATCHDOG_LIMIT   = 4000;
    // Length of the long receiver hold-off that fills the pipeline.
    localparam int  HOLD_CYCLES      = 120;
    localparam int  FLOOD_BOXES      = 48;
    localparam int  RANDOM_PER_PHASE = 230;
    localparam int  DRAIN_CYCLES     = 16;
    localparam int  POS_TOP          = 8388607;
    localparam int  POS_BOTTOM       = -8388608;
    localparam int  Q_ONE            = 16384;
    // cos(45 deg) in Q1.14, used for quarter turns about one axis.
    localparam int  Q_HALF_SQRT2     = 11585;
    localparam real HALF_TURN        = 3.14159265358979;

    typedef enum int
    {
        RX_READY,
        RX_LIGHT,
        RX_PATTERN,
        RX_HEAVY
    } rx_mode_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // Fields from bit 0 up: box_length, box_width, centre_x, centre_y, centre_z,
    // quat_x, quat_y, quat_z, quat_w.
    logic [cbncr_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // Fields from bit 0 up: new_length, new_width, new_centre_x, new_centre_y,
    // new_centre_z.
    logic [cbncr_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [cbncr_pkg::PADDR_W-1:0]      paddr    = '0;
    logic [cbncr_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [cbncr_pkg::APB_DATA_W-1:0]   prdata;
    logic                               pready;

    int       refits_pending;
    int       mismatch_count;
    // Hold-offs asked for by the stimulus and hold-offs already served by the receiver.
    int       holds_asked  = 0;
    int       holds_served = 0;
    bit       gaps_on    = 1'b1;
    int       burst_left = 0;
    int       idle_cycles = 0;
    // Copy of the bounds last written; it only steers the stimulus toward the edges.
    int       bounds [4] = '{0, 0, 0, 0};
    rx_mode_t rx_mode;
    int       rx_stretch;
    int       rx_pos = 0;
    logic [7:0] rx_pattern;

    car_box_nearest_corner_refit_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cbncr_refit_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .refits_pending (refits_pending),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Uniform integer in [-lim, lim].
    function automatic int span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [cbncr_pkg::IN_DATA_W-1:0] pack_box(
        input int len, input int wid, input int cx, input int cy, input int cz,
        input int qx, input int qy, input int qz, input int qw);
        return {16'(qw), 16'(qz), 16'(qy), 16'(qx), 24'(cz), 24'(cy), 24'(cx),
                16'(wid), 16'(len)};
    endfunction

    // Extents cluster around the two bounds so that both sides of each strict
    // comparison are hit often; zero and full scale come up now and then.
    function automatic int make_extent(input int lo, input int hi);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 65535;
        if (sel <= 4)
            return $urandom_range(0, 65535);
        if (sel <= 8)
            return (lo + span(2)) & 16'hFFFF;
        if (sel <= 12)
            return (hi + span(2)) & 16'hFFFF;
        if (hi > lo + 1)
            return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(1, 65535);
    endfunction

    // One random box. Most boxes sit near the origin and most use a unit quaternion, which is
    // where the nearest-corner choice is interesting; the rest spread the centre out up to
    // full scale (saturation) or use arbitrary, non-unit quaternions.
    function automatic logic [cbncr_pkg::IN_DATA_W-1:0] make_box();
        int len, wid, cx, cy, cz, qx, qy, qz, qw, sel;
        real ang, a, b, c, d, norm;
        len = make_extent(bounds[cbncr_pkg::CFG_LENGTH_LOWER],
                          bounds[cbncr_pkg::CFG_LENGTH_UPPER]);
        wid = make_extent(bounds[cbncr_pkg::CFG_WIDTH_LOWER],
                          bounds[cbncr_pkg::CFG_WIDTH_UPPER]);

        sel = $urandom_range(0, 9);
        if (sel <= 5)
        begin
            cx = span(8192);
            cy = span(8192);
            cz = span(2048);
        end
        else if (sel <= 7)
        begin
            cx = span(400000);
            cy = span(400000);
            cz = span(20000);
        end
        else if (sel == 8)
        begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
        end
        else
        begin
            cx = $urandom_range(0, 1) ? POS_TOP : POS_BOTTOM;
            cy = $urandom_range(0, 1) ? POS_TOP : POS_BOTTOM;
            cz = $urandom_range(0, 1) ? POS_TOP : POS_BOTTOM;
        end

        sel = $urandom_range(0, 9);
        if (sel <= 4)
        begin
            // Pure heading, the usual case for a vehicle on the ground.
            ang = real'($urandom_range(0, 3599)) * HALF_TURN / 1800.0;
            qx = 0;
            qy = 0;
            qz = int'(16384.0 * $sin(ang / 2.0));
            qw = int'(16384.0 * $cos(ang / 2.0));
            if ($urandom_range(0, 1))
            begin
                qz = -qz;
                qw = -qw;
            end
        end
        else if (sel <= 7)
        begin
            a = real'(span(1000));
            b = real'(span(1000));
            c = real'(span(1000));
            d = real'(span(1000));
            norm = $sqrt(a * a + b * b + c * c + d * d);
            if (norm < 1.0)
            begin
                d = 1.0;
                norm = 1.0;
            end
            qx = int'(16384.0 * a / norm);
            qy = int'(16384.0 * b / norm);
            qz = int'(16384.0 * c / norm);
            qw = int'(16384.0 * d / norm);
        end
        else if (sel == 8)
        begin
            qx = span(Q_ONE);
            qy = span(Q_ONE);
            qz = span(Q_ONE);
            qw = span(Q_ONE);
        end
        else
        begin
            qx = Q_ONE * (int'($urandom_range(0, 2)) - 1);
            qy = Q_ONE * (int'($urandom_range(0, 2)) - 1);
            qz = Q_ONE * (int'($urandom_range(0, 2)) - 1);
            qw = Q_ONE * (int'($urandom_range(0, 2)) - 1);
        end
        return pack_box(len, wid, cx, cy, cz, qx, qy, qz, qw);
    endfunction

    // Register write: setup cycle, then access cycle held until pready.
    task automatic apb_write(input cbncr_pkg::cfg_idx_t idx, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= cbncr_pkg::APB_DATA_W'(value & 16'hFFFF);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bounds[idx] = value & 16'hFFFF;
    endtask

    task automatic apply_bounds(input int wl, input int wu, input int ll, input int lu);
        apb_write(cbncr_pkg::CFG_WIDTH_LOWER, wl);
        apb_write(cbncr_pkg::CFG_WIDTH_UPPER, wu);
        apb_write(cbncr_pkg::CFG_LENGTH_LOWER, ll);
        apb_write(cbncr_pkg::CFG_LENGTH_UPPER, lu);
    endtask

    // Offers one box and returns at the edge where the transfer completes. Boxes go
    // out in bursts of random length; between bursts tvalid drops for a random gap,
    // which is sometimes zero so that long back-to-back stretches also occur.
    task automatic send_box(input logic [cbncr_pkg::IN_DATA_W-1:0] box);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = 0;
            if (gaps_on && ($urandom_range(0, 3) != 0))
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= box;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Waits until every predicted result has been taken off the output.
    // Always advances at least one edge, so the checker's count is up to date.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (refits_pending != 0);
    endtask

    // Receiver: runs stretches of random length, each with its own stall behavior.
    // When the top asks for a hold-off, tready stays low for HOLD_CYCLES so the
    // pipeline fills and the input side stalls.
    initial
    begin
        forever
        begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            rx_stretch = $urandom_range(16, 160);
            rx_pattern = 8'($urandom) | 8'h01;
            repeat (rx_stretch)
            begin
                @(posedge clk);
                if (holds_asked != holds_served)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    holds_served++;
                end
                case (rx_mode)
                    RX_READY:   m_tready <= 1'b1;
                    RX_LIGHT:   m_tready <= ($urandom_range(0, 99) >= 30);
                    RX_PATTERN:
                    begin
                        m_tready <= rx_pattern[rx_pos % 8];
                        rx_pos++;
                    end
                    default:    m_tready <= ($urandom_range(0, 99) >= 80);
                endcase
            end
        end
    end

    // Watchdog: any transfer on either stream or the register port restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // Driven after all processes have started, so the falling reset edge is seen.
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed boxes under the reset bounds: width (1229, 2253), length (3072, 5120).
        // All-zero box: zero dimensions and a zero quaternion.
        send_box(pack_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Identity rotation, both dimensions inside their ranges.
        send_box(pack_box(4000, 1800, 10240, 5120, 0, 0, 0, 0, Q_ONE));
        // Dimensions exactly on a bound are out of range (bounds are exclusive).
        send_box(pack_box(3072, 2253, 20480, -10240, 512, 0, 0, 0, Q_ONE));
        send_box(pack_box(5120, 1229, -20480, 10240, -512, 0, 0, 0, Q_ONE));
        // One step inside each bound.
        send_box(pack_box(3073, 2252, -7000, -9000, 100, 0, 0, 0, Q_ONE));
        send_box(pack_box(5119, 1230, 7000, 9000, -100, 0, 0, 0, Q_ONE));
        // Full-scale dimensions at the positive and negative centre limits.
        send_box(pack_box(65535, 65535, POS_TOP, POS_TOP, POS_TOP, 0, 0, 0, Q_ONE));
        send_box(pack_box(65535, 65535, POS_BOTTOM, POS_BOTTOM, POS_BOTTOM,
                          0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2));
        // Zero length only, then zero width only: no shift along that axis.
        send_box(pack_box(0, 2000, 3000, 4000, 0, 0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2));
        send_box(pack_box(4500, 0, -3000, 4000, 0, 0, 0, 0, Q_ONE));
        // Centre on the origin: all four corners are equally far, the first one wins.
        send_box(pack_box(6000, 3000, 0, 0, 0, 0, 0, 0, Q_ONE));
        send_box(pack_box(6000, 3000, 0, 0, 0, 0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2));
        // Non-unit quaternions: all components at full scale, then all at minus full.
        send_box(pack_box(2500, 2500, 1000, -2000, 300, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_box(pack_box(2500, 2500, 1000, -2000, 300, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE));
        // Negated identity describes the same rotation.
        send_box(pack_box(6000, 1000, 5000, 5000, 0, 0, 0, 0, -Q_ONE));
        // Quarter turns about x and y move the corners off the ground plane.
        send_box(pack_box(4000, 3000, 8000, -6000, 2000, Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2));
        send_box(pack_box(6000, 1000, -8000, 6000, -2000, 0, Q_HALF_SQRT2, 0, Q_HALF_SQRT2));
        // Half turn about x.
        send_box(pack_box(7000, 500, 4000, 4000, 4000, Q_ONE, 0, 0, 0));
        // Tiny box with mixed extreme centre bits.
        send_box(pack_box(1, 1, -1, POS_TOP, POS_BOTTOM, 0, 0, 0, Q_ONE));
        send_box(pack_box(1, 65535, 123456, -654321, 77, -1, 1, -2, 2));
        s_tvalid <= 1'b0;
        wait_idle();

        // Random phases, each under its own bounds. The block is idle before every
        // register write because all predicted results have come back.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apply_bounds(1229, 2253, 3072, 5120);
                1: apply_bounds(0, 0, 0, 0);
                2: apply_bounds(65535, 65535, 65535, 65535);
                3: apply_bounds(0, 65535, 0, 65535);
                4: apply_bounds(3000, 1000, 6000, 2000);
                default: apply_bounds($urandom_range(0, 65535), $urandom_range(0, 65535),
                                      $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase

            if (ph == 0)
            begin
                // Output held off while boxes keep coming: fills the pipeline.
                holds_asked++;
                gaps_on = 1'b0;
                for (int i = 0; i < FLOOD_BOXES; i++)
                    send_box(make_box());
                gaps_on = 1'b1;
            end

            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i == RANDOM_PER_PHASE / 2)
                begin
                    // Sender pauses until the pipeline has fully drained.
                    s_tvalid <= 1'b0;
                    wait_idle();
                end
                send_box(make_box());
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[car_box_nearest_corner_refit_core.f]
+incdir+design
design/cbncr_pkg.sv
design/cbncr_cfg_regs.sv
design/car_box_nearest_corner_refit_core.sv
tb/cbncr_refit_checker.sv
tb/car_box_nearest_corner_refit_core_tb.sv
